// ===== design/vssf_pkg.sv =====
// Shared constants, register codes and types for the vital-sign smoothing filter.
package vssf_pkg;

    localparam int HIST_DEPTH = 16;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int VAL_W      = 8;
    localparam int CHECK_TAPS = 4;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_RATE_LOW   = 3'd0;
    localparam logic [2:0] REG_RATE_HIGH  = 3'd1;
    localparam logic [2:0] REG_OXY_LOW    = 3'd2;
    localparam logic [2:0] REG_JUMP       = 3'd3;
    localparam logic [2:0] REG_STREAK_CHK = 3'd4;
    localparam logic [2:0] REG_REJECT_TOL = 3'd5;

    localparam logic [7:0] RATE_LOW_RST   = 8'd40;
    localparam logic [7:0] RATE_HIGH_RST  = 8'd190;
    localparam logic [6:0] OXY_LOW_RST    = 7'd59;
    localparam logic [5:0] JUMP_RST       = 6'd10;
    localparam logic [2:0] STREAK_CHK_RST = 3'd4;
    localparam logic [2:0] REJECT_TOL_RST = 3'd4;

    typedef struct packed {
        logic [5:0] jump;
        logic [2:0] streak_chk;
        logic [2:0] reject_tol;
    } t_chan_cfg;

endpackage

// ===== design/vssf_chan.sv =====
// One filter channel: outlier check, history shift line, fill tracking and windowed mean.
module vssf_chan
    import vssf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_ok,
    input  logic [VAL_W-1:0] i_value,
    input  logic             i_upward,
    input  t_chan_cfg        i_cfg,
    output logic             o_taken,
    output logic [VAL_W-1:0] o_mean
);

    logic [VAL_W-1:0]  r_hist [HIST_DEPTH];
    logic [VAL_W-1:0]  n_hist [HIST_DEPTH];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [2:0]        r_streak, n_streak;
    logic [2:0]        r_misses, n_misses;
    logic [VAL_W-1:0]  r_mean, n_mean;

    logic [VAL_W:0]    near_lhs [CHECK_TAPS];
    logic [VAL_W:0]    near_rhs [CHECK_TAPS];
    logic              any_near;
    logic              drop;
    logic              take;

    logic [VAL_W-1:0]  pad [16];
    logic [VAL_W:0]    lvl1 [8];
    logic [VAL_W+1:0]  lvl2 [4];
    logic [VAL_W+2:0]  lvl3 [2];
    logic [VAL_W+3:0]  lvl4;
    logic [VAL_W+3:0]  win_sum;

    always_comb begin
        any_near = 1'b0;
        for (int i = 0; i < CHECK_TAPS; i++) begin
            if (i_upward) begin
                near_lhs[i] = {1'b0, i_value};
                near_rhs[i] = {1'b0, r_hist[i]} + {{(VAL_W-5){1'b0}}, i_cfg.jump};
            end else begin
                near_lhs[i] = {1'b0, r_hist[i]};
                near_rhs[i] = {1'b0, i_value} + {{(VAL_W-5){1'b0}}, i_cfg.jump};
            end
            if (near_lhs[i] < near_rhs[i]) begin
                any_near = 1'b1;
            end
        end
    end

    always_comb begin
        n_streak = r_streak;
        n_misses = r_misses;
        drop     = 1'b0;
        if (!i_ok) begin
            n_streak = 3'd0;
            if (r_misses != i_cfg.reject_tol) begin
                n_misses = 3'(r_misses + 3'd1);
            end
        end else begin
            n_misses = 3'd0;
            if (r_streak == i_cfg.streak_chk) begin
                drop = !any_near;
                if (drop) begin
                    n_streak = 3'd0;
                end
            end else begin
                n_streak = 3'(r_streak + 3'd1);
            end
        end
        take = i_ok && !drop;
    end

    always_comb begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            n_hist[i] = r_hist[i];
        end
        n_fill = r_fill;
        if (take) begin
            n_hist[0] = i_value;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                n_hist[i] = r_hist[i-1];
            end
            if (int'(r_fill) < HIST_DEPTH) begin
                n_fill = FILL_W'(r_fill + 1'b1);
            end
        end else if (!i_ok && r_misses == i_cfg.reject_tol) begin
            n_fill = '0;
        end
    end

    // The window sums come from a fixed adder tree over the newest sixteen entries.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (i < HIST_DEPTH) begin
                pad[i] = n_hist[i];
            end else begin
                pad[i] = '0;
            end
        end
        for (int i = 0; i < 8; i++) begin
            lvl1[i] = {1'b0, pad[2*i]} + {1'b0, pad[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
        end
        lvl4 = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};

        if (int'(n_fill) >= 16) begin
            win_sum = lvl4 >> 4;
        end else if (int'(n_fill) >= 8) begin
            win_sum = {1'b0, lvl3[0]} >> 3;
        end else if (int'(n_fill) >= 4) begin
            win_sum = {2'b0, lvl2[0]} >> 2;
        end else begin
            win_sum = {3'b0, lvl1[0]} >> 1;
        end

        n_mean = r_mean;
        if (take) begin
            if (int'(n_fill) < 2) begin
                n_mean = '0;
            end else begin
                n_mean = win_sum[VAL_W-1:0];
            end
        end else if (!i_ok && r_misses == i_cfg.reject_tol) begin
            n_mean = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_fill   <= '0;
            r_streak <= '0;
            r_misses <= '0;
            r_mean   <= '0;
        end else if (i_en) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= n_hist[i];
            end
            r_fill   <= n_fill;
            r_streak <= n_streak;
            r_misses <= n_misses;
            r_mean   <= n_mean;
        end
    end

    assign o_taken = take;
    assign o_mean  = n_mean;

endmodule

// ===== design/vital_sign_smoothing_filter_core.sv =====
// Top level of the vital-sign smoothing filter: register port, stream stages, two channels.
// Each input word is held in the input stage; its result word is registered in the output register.
// Throughput: one word per cycle with no output stall; each channel updates history and mean.
// The input stage and the output register let a new word enter while a result waits.
// Reset is synchronous and active low; it clears histories, counters, means and
// restores the default limits.
module vital_sign_smoothing_filter_core
    import vssf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [15:0]       i_s_tdata,  // rate_estimate[7:0], oxygen_estimate[14:8], zero[15]
    input  logic [1:0]        i_s_tuser,  // rate_ok[0], oxygen_ok[1]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata,  // rate_average[7:0], oxygen_average[14:8], zero[15]
    output logic [1:0]        o_m_tuser,  // rate_taken[0], oxygen_taken[1]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0]  r_rate_low;
    logic [7:0]  r_rate_high;
    logic [6:0]  r_oxy_low;
    logic [5:0]  r_jump;
    logic [2:0]  r_streak_chk;
    logic [2:0]  r_reject_tol;
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    logic        r_in_valid;
    logic [7:0]  r_in_rate;
    logic        r_in_rate_ok;
    logic [6:0]  r_in_oxy;
    logic        r_in_oxy_ok;
    logic        fire;

    logic        r_out_valid;
    logic [7:0]  r_out_rate;
    logic [6:0]  r_out_oxy;
    logic [1:0]  r_out_taken;

    t_chan_cfg   chan_cfg;
    logic        rate_qual;
    logic        oxy_qual;
    logic        rate_taken;
    logic        oxy_taken;
    logic [7:0]  rate_mean;
    logic [7:0]  oxy_mean;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_low   <= RATE_LOW_RST;
            r_rate_high  <= RATE_HIGH_RST;
            r_oxy_low    <= OXY_LOW_RST;
            r_jump       <= JUMP_RST;
            r_streak_chk <= STREAK_CHK_RST;
            r_reject_tol <= REJECT_TOL_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RATE_LOW:   r_rate_low   <= pwdata[7:0];
                REG_RATE_HIGH:  r_rate_high  <= pwdata[7:0];
                REG_OXY_LOW:    r_oxy_low    <= pwdata[6:0];
                REG_JUMP:       r_jump       <= pwdata[5:0];
                REG_STREAK_CHK: r_streak_chk <= pwdata[2:0];
                REG_REJECT_TOL: r_reject_tol <= pwdata[2:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RATE_LOW:   prdata = {24'd0, r_rate_low};
            REG_RATE_HIGH:  prdata = {24'd0, r_rate_high};
            REG_OXY_LOW:    prdata = {25'd0, r_oxy_low};
            REG_JUMP:       prdata = {26'd0, r_jump};
            REG_STREAK_CHK: prdata = {29'd0, r_streak_chk};
            REG_REJECT_TOL: prdata = {29'd0, r_reject_tol};
            default:        prdata = 32'd0;
        endcase
    end

    assign fire       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_rate    <= i_s_tdata[7:0];
            r_in_oxy     <= i_s_tdata[14:8];
            r_in_rate_ok <= i_s_tuser[0];
            r_in_oxy_ok  <= i_s_tuser[1];
        end
    end

    assign chan_cfg.jump       = r_jump;
    assign chan_cfg.streak_chk = r_streak_chk;
    assign chan_cfg.reject_tol = r_reject_tol;

    assign rate_qual = r_in_rate_ok && (r_in_rate < r_rate_high) && (r_in_rate > r_rate_low);
    assign oxy_qual  = r_in_oxy_ok && (r_in_oxy > r_oxy_low);

    vssf_chan u_rate_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (fire),
        .i_ok     (rate_qual),
        .i_value  (r_in_rate),
        .i_upward (1'b1),
        .i_cfg    (chan_cfg),
        .o_taken  (rate_taken),
        .o_mean   (rate_mean)
    );

    vssf_chan u_oxy_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (fire),
        .i_ok     (oxy_qual),
        .i_value  ({1'b0, r_in_oxy}),
        .i_upward (1'b0),
        .i_cfg    (chan_cfg),
        .o_taken  (oxy_taken),
        .o_mean   (oxy_mean)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_rate  <= rate_mean;
            r_out_oxy   <= oxy_mean[6:0];
            r_out_taken <= {oxy_taken, rate_taken};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_oxy, r_out_rate};
    assign o_m_tuser  = r_out_taken;

endmodule

// ===== design/vssf_checker.sv =====
// Port-level checker for the vital-sign smoothing filter, bound to the top level.
module vssf_checker
    import vssf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        pready
);

    // A stalled result word must hold its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    // With no result waiting, the input side can never be blocked.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked while output is empty");

    // The saturation average never exceeds seven bits.
    a_oxy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15] == 1'b0)
        else $error("saturation average out of range");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port not ready");

endmodule

bind vital_sign_smoothing_filter_core vssf_checker u_vssf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);

// ===== tb/vital_sign_smoothing_filter_core_tb.sv =====
// Testbench for the vital-sign smoothing filter core: predicting scoreboard, stream and APB drivers.
module vital_sign_smoothing_filter_core_tb
    import vssf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 150;
    localparam logic [2:0] REG_UNUSED  = 3'd6;

    typedef struct {
        logic [7:0] rate_avg;
        logic [6:0] oxy_avg;
        logic       rate_taken;
        logic       oxy_taken;
    } t_average_word;

    class smoothing_scoreboard;
        int rate_lo, rate_hi, oxy_lo, jump, streak_chk, reject_tol;
        int hist[2][HIST_DEPTH];
        int fill[2];
        int streak[2];
        int misses[2];
        int mean[2];
        int errors;
        t_average_word expected_averages[$];

        function new();
            rate_lo    = RATE_LOW_RST;
            rate_hi    = RATE_HIGH_RST;
            oxy_lo     = OXY_LOW_RST;
            jump       = JUMP_RST;
            streak_chk = STREAK_CHK_RST;
            reject_tol = REJECT_TOL_RST;
            errors     = 0;
            for (int c = 0; c < 2; c++) begin
                fill[c]   = 0;
                streak[c] = 0;
                misses[c] = 0;
                mean[c]   = 0;
                for (int i = 0; i < HIST_DEPTH; i++) begin
                    hist[c][i] = 0;
                end
            end
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_RATE_LOW:   rate_lo    = val[7:0];
                REG_RATE_HIGH:  rate_hi    = val[7:0];
                REG_OXY_LOW:    oxy_lo     = val[6:0];
                REG_JUMP:       jump       = val[5:0];
                REG_STREAK_CHK: streak_chk = val[2:0];
                REG_REJECT_TOL: reject_tol = val[2:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the value enters the channel history.
        function bit channel_step(int ch, bit ok, int v, bit upward);
            int  n, w, sh, sum;
            bit  drop;
            bit  near_entry;
            drop = 1'b0;
            if (!ok) begin
                streak[ch] = 0;
                if (misses[ch] == reject_tol) begin
                    fill[ch] = 0;
                    mean[ch] = 0;
                end else begin
                    misses[ch] = (misses[ch] + 1) & 7;
                end
                return 1'b0;
            end
            misses[ch] = 0;
            if (streak[ch] == streak_chk) begin
                drop = 1'b1;
                for (int i = 0; i < CHECK_TAPS; i++) begin
                    near_entry = upward ? (v < hist[ch][i] + jump) : (v + jump > hist[ch][i]);
                    if (near_entry) drop = 1'b0;
                end
                if (drop) streak[ch] = 0;
            end else begin
                streak[ch] = (streak[ch] + 1) & 7;
            end
            if (drop) return 1'b0;
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                hist[ch][i] = hist[ch][i-1];
            end
            hist[ch][0] = v;
            if (fill[ch] < HIST_DEPTH) fill[ch]++;
            n = fill[ch];
            if (n < 2) begin
                mean[ch] = 0;
            end else begin
                w   = 2;
                sh  = 1;
                sum = 0;
                while (sh < 4 && w * 2 <= n && w * 2 <= HIST_DEPTH) begin
                    w  = w * 2;
                    sh = sh + 1;
                end
                for (int i = 0; i < w; i++) begin
                    sum += hist[ch][i];
                end
                mean[ch] = sum >> sh;
            end
            return 1'b1;
        endfunction

        function void note_reading(logic [7:0] rate, bit rate_ok, logic [6:0] oxy, bit oxy_ok);
            t_average_word w;
            bit            rate_q, oxy_q;
            rate_q       = rate_ok && (rate < rate_hi) && (rate > rate_lo);
            oxy_q        = oxy_ok && (oxy > oxy_lo);
            w.rate_taken = channel_step(0, rate_q, int'(rate), 1'b1);
            w.oxy_taken  = channel_step(1, oxy_q, int'(oxy), 1'b0);
            w.rate_avg   = mean[0][7:0];
            w.oxy_avg    = mean[1][6:0];
            expected_averages.push_back(w);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_average_word(logic [15:0] data, logic [1:0] user);
            t_average_word w;
            if (expected_averages.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%h user=%b", data, user));
                return;
            end
            w = expected_averages.pop_front();
            if (data[7:0] !== w.rate_avg)
                report_mismatch($sformatf("rate_average %0d, want %0d", data[7:0], w.rate_avg));
            if (data[14:8] !== w.oxy_avg)
                report_mismatch($sformatf("oxygen_average %0d, want %0d", data[14:8], w.oxy_avg));
            if (data[15] !== 1'b0)
                report_mismatch("padding bit of tdata not zero");
            if (user[0] !== w.rate_taken)
                report_mismatch($sformatf("rate_taken %b, want %b", user[0], w.rate_taken));
            if (user[1] !== w.oxy_taken)
                report_mismatch($sformatf("oxygen_taken %b, want %b", user[1], w.oxy_taken));
        endtask

        function int pending();
            return expected_averages.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [15:0]       i_s_tdata = '0;  // rate_estimate[7:0], oxygen_estimate[14:8], zero[15]
    logic [1:0]        i_s_tuser = '0;  // rate_ok[0], oxygen_ok[1]
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [15:0]       o_m_tdata;       // rate_average[7:0], oxygen_average[14:8], zero[15]
    logic [1:0]        o_m_tuser;       // rate_taken[0], oxygen_taken[1]
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    smoothing_scoreboard sb = new();

    bit gaps_on   = 1'b1;
    bit hold_go   = 1'b0;
    int hold_left = 0;
    int cycle_count = 0;
    int rate_base = 80;
    int oxy_base  = 95;

    vital_sign_smoothing_filter_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_reading(i_s_tdata[7:0], i_s_tuser[0], i_s_tdata[14:8], i_s_tuser[1]);
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_average_word(o_m_tdata, o_m_tuser);
    end

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_go   = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (gaps_on) begin
            i_m_tready <= ($urandom_range(99) >= 29);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_register(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_limits(int rlo, int rhi, int olo, int jmp, int stk, int tol);
        apb_write(REG_RATE_LOW, rlo);
        apb_write(REG_RATE_HIGH, rhi);
        apb_write(REG_OXY_LOW, olo);
        apb_write(REG_JUMP, jmp);
        apb_write(REG_STREAK_CHK, stk);
        apb_write(REG_REJECT_TOL, tol);
    endtask

    task automatic offer_reading(logic [7:0] rate, bit rate_ok, logic [6:0] oxy, bit oxy_ok);
        while (gaps_on && $urandom_range(99) < 29) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, oxy, rate};
        i_s_tuser  <= {oxy_ok, rate_ok};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic int clip(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // Mostly steady readings around a drifting base, some outliers, some noise.
    task automatic random_readings(int count);
        int pick, r, o;
        bit rok, ook;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if ($urandom_range(29) == 0) begin
                rate_base = clip(rate_base + $urandom_range(20) - 10, 250);
                oxy_base  = clip(oxy_base + $urandom_range(10) - 5, 125);
            end
            rok = ($urandom_range(19) != 0);
            ook = ($urandom_range(19) != 0);
            if (pick < 75) begin
                r = clip(rate_base + $urandom_range(8) - 4, 255);
                o = clip(oxy_base + $urandom_range(6) - 3, 127);
            end else if (pick < 88) begin
                r = clip(rate_base + sb.jump + $urandom_range(30), 255);
                o = clip(oxy_base - sb.jump - $urandom_range(20), 127);
            end else begin
                r   = $urandom_range(255);
                o   = $urandom_range(127);
                rok = 1'($urandom_range(1));
                ook = 1'($urandom_range(1));
            end
            offer_reading(8'(r), rok, 7'(o), ook);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed readings at the reset limits.
        offer_reading(8'd0, 1'b1, 7'd0, 1'b1);
        offer_reading(8'd255, 1'b1, 7'd127, 1'b1);
        offer_reading(8'd41, 1'b1, 7'd60, 1'b1);
        offer_reading(8'd189, 1'b1, 7'd60, 1'b1);
        offer_reading(8'd40, 1'b1, 7'd59, 1'b1);
        offer_reading(8'd190, 1'b0, 7'd100, 1'b0);
        repeat (4) offer_reading(8'd70, 1'b1, 7'd95, 1'b1);
        offer_reading(8'd80, 1'b1, 7'd85, 1'b1);
        offer_reading(8'd79, 1'b1, 7'd86, 1'b1);
        repeat (5) offer_reading(8'd100, 1'b0, 7'd100, 1'b0);
        offer_reading(8'd100, 1'b1, 7'd100, 1'b1);
        offer_reading(8'd101, 1'b1, 7'd101, 1'b1);
        offer_reading(8'd102, 1'b1, 7'd102, 1'b1);
        drain_results();

        // Widest limits, zero jump, zero streak and zero tolerance.
        write_limits(0, 255, 0, 0, 0, 0);
        apb_write(REG_UNUSED, 32'h5A);
        random_readings(150);
        drain_results();

        // Inverted limits: nothing qualifies.
        write_limits(200, 100, 127, 63, 7, 7);
        random_readings(60);
        drain_results();

        // Default limits with a long stretch free of gaps and one long receiver stall.
        write_limits(int'(RATE_LOW_RST), int'(RATE_HIGH_RST), int'(OXY_LOW_RST),
                     int'(JUMP_RST), int'(STREAK_CHK_RST), int'(REJECT_TOL_RST));
        gaps_on = 1'b0;
        random_readings(200);
        gaps_on = 1'b1;
        random_readings(50);
        hold_go = 1'b1;
        random_readings(150);
        drain_results();

        repeat (4) begin
            write_limits($urandom_range(120), $urandom_range(255, 100), $urandom_range(100),
                         $urandom_range(63), $urandom_range(7), $urandom_range(7));
            rate_base = $urandom_range(170, 50);
            oxy_base  = $urandom_range(120, 70);
            random_readings(100);
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d expected words never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
